@@ hdl/stmh_pkg.sv @@
// ----------------------------------------------------------------------------
// stmh_pkg: shared types and codes for the speed toggle mode handshake
// Word layouts, configuration record, command/status/phase codes.
// ----------------------------------------------------------------------------
package stmh_pkg;

    localparam int FREQ_W  = 16;
    localparam int TIME_W  = 48;
    localparam int DWELL_W = 32;
    localparam int LIMIT_W = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Attempt count offsets used by the fail check and the timeout path
    localparam logic [COUNT_W:0]   FAIL_OFFSET    = 6'd2;
    localparam logic [COUNT_W-1:0] TIMEOUT_OFFSET = 5'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DWELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIMIT = 3'd4;

    // Reset values of the configuration registers
    localparam logic [FREQ_W-1:0]  LOW_THR_RST   = 16'd1536;
    localparam logic [FREQ_W-1:0]  HIGH_THR_RST  = 16'd2560;
    localparam logic [DWELL_W-1:0] MIN_DWELL_RST = 32'd1000000;
    localparam logic [DWELL_W-1:0] MAX_DWELL_RST = 32'd10000000;
    localparam logic [LIMIT_W-1:0] ATT_LIMIT_RST = 4'd3;

    typedef enum logic [0:0] {
        ACT_START  = 1'b0,
        ACT_REPORT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_LOW  = 2'd1,
        CMD_HIGH = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_RUN     = 3'd1,
        ST_OPENED  = 3'd2,
        ST_FAILED  = 3'd3,
        ST_LOW_TO  = 3'd4,
        ST_HIGH_TO = 3'd5
    } status_t;

    // Handshake phases, one-hot
    typedef enum logic [5:0] {
        PH_CMD_LOW    = 6'b000001,
        PH_WAIT_LOW   = 6'b000010,
        PH_CONF_LOW   = 6'b000100,
        PH_CMD_HIGH   = 6'b001000,
        PH_WAIT_HIGH  = 6'b010000,
        PH_CONF_HIGH  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [0:0]        action;
        logic [FREQ_W-1:0] frequency;
        logic [TIME_W-1:0] timestamp;
        logic              check_flag;
    } item_t;

    typedef struct packed {
        logic [1:0] speed_command;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  low_thr;
        logic [FREQ_W-1:0]  high_thr;
        logic [DWELL_W-1:0] min_dwell;
        logic [DWELL_W-1:0] max_dwell;
        logic [LIMIT_W-1:0] att_limit;
    } cfg_t;

endpackage

@@ hdl/speed_toggle_mode_handshake.sv @@
// ----------------------------------------------------------------------------
// speed_toggle_mode_handshake: speed toggle mode handshake controller
// Sequences low/high speed commands from frequency reports and decides the
// outcome of the mode handshake.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per start event
//   (action 0) or frequency report (action 1) with frequency, timestamp and
//   check_flag. Every input word yields exactly one output word on the
//   out_valid/out_ready channel: speed_command and status.
//   Configuration registers (thresholds, dwell limits, attempt limit) are
//   written through cfg_write/cfg_index/cfg_data while no word is in flight;
//   writes take effect on the next clock.
//   An accepted word is registered in the input register, stepped through
//   the phase logic and lands in the output register, from which it is
//   taken on the out_valid/out_ready channel.
//   Throughput: one word per cycle while the output register is not stalled.
//   The step logic (one 49-bit dwell subtract plus compares) is combinational,
//   and the handshake state is updated as each word moves to the output register.
//   Stall: while the output register is full and out_ready is low, the input
//   register holds its word and in_ready drops once it is occupied too.
//   Reset: asynchronous, active low; handshake goes idle, configuration
//   registers take their defaults, both channels empty.
// ----------------------------------------------------------------------------
module speed_toggle_mode_handshake (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [stmh_pkg::FREQ_W-1:0]         frequency,
    input  logic [stmh_pkg::TIME_W-1:0]         timestamp,
    input  logic                                check_flag,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          speed_command,
    output logic [2:0]                          status,
    // configuration
    input  logic                                cfg_write,
    input  logic [stmh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stmh_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import stmh_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   stage_item;
    logic    stage_valid;
    logic    advance;
    result_t step_result;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign in_item.action     = action;
    assign in_item.frequency  = frequency;
    assign in_item.timestamp  = timestamp;
    assign in_item.check_flag = check_flag;

    stmh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stmh_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .take        (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // Step a word when the output register is free or being drained
    assign advance = stage_valid && (!out_valid_reg || out_ready);

    stmh_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_item),
        .cfg    (cfg),
        .result (step_result)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign speed_command = result_reg.speed_command;
    assign status        = result_reg.status;

`ifndef NO_ASSERTIONS
    // A word waiting in the input register is never dropped while stalled
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !advance) |=> stage_valid)
        else $error("input stage word lost during stall");

    // Every stepped word shows up in the output register
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped word missing from output register");

    // The output register is never overwritten while it holds an untaken word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("output word overwritten before being taken");

    // An idle report never carries a speed command
    a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status == ST_IDLE)) |->
            (result_reg.speed_command == CMD_NONE))
        else $error("speed command issued while idle");
`endif

endmodule

@@ hdl/stmh_cfg.sv @@
// ----------------------------------------------------------------------------
// stmh_cfg: configuration register file
// Write-only registers loaded by index from the configuration port.
// ----------------------------------------------------------------------------
module stmh_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [stmh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stmh_pkg::CFG_DATA_W-1:0]     cfg_data,
    output stmh_pkg::cfg_t                      cfg
);
    import stmh_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_thr   <= LOW_THR_RST;
            cfg_reg.high_thr  <= HIGH_THR_RST;
            cfg_reg.min_dwell <= MIN_DWELL_RST;
            cfg_reg.max_dwell <= MAX_DWELL_RST;
            cfg_reg.att_limit <= ATT_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LOW_THR:   cfg_reg.low_thr   <= cfg_data[FREQ_W-1:0];
                CFG_HIGH_THR:  cfg_reg.high_thr  <= cfg_data[FREQ_W-1:0];
                CFG_MIN_DWELL: cfg_reg.min_dwell <= cfg_data[DWELL_W-1:0];
                CFG_MAX_DWELL: cfg_reg.max_dwell <= cfg_data[DWELL_W-1:0];
                CFG_ATT_LIMIT: cfg_reg.att_limit <= cfg_data[LIMIT_W-1:0];
                default:       ;  // unused index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/stmh_in_stage.sv @@
// ----------------------------------------------------------------------------
// stmh_in_stage: input register
// Holds one accepted word until the step logic consumes it.
// ----------------------------------------------------------------------------
module stmh_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  stmh_pkg::item_t in_item,
    input  logic            take,
    output logic            stage_valid,
    output stmh_pkg::item_t stage_item
);
    import stmh_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  fire;

    // Empty, or emptied this cycle
    assign in_ready = !valid_reg || take;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

@@ hdl/stmh_core.sv @@
// ----------------------------------------------------------------------------
// stmh_core: handshake state and step logic
// Phase sequencer, attempt counter and dwell timer; one word per step.
// ----------------------------------------------------------------------------
module stmh_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  stmh_pkg::item_t   item,
    input  stmh_pkg::cfg_t    cfg,
    output stmh_pkg::result_t result
);
    import stmh_pkg::*;

    logic               active_reg, active_next;
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]  mark_reg, mark_next;

    logic [TIME_W:0]    diff;
    logic               backwards;
    logic               over_min;
    logic               over_max;
    logic               low_hit;
    logic               high_hit;
    logic [COUNT_W-1:0] limit_ext;
    logic [COUNT_W-1:0] timeout_count;
    logic [COUNT_W:0]   fail_count;
    logic               flag;
    cmd_t               cmd;
    status_t            st;

    // Dwell since the mark; a negative dwell neither confirms nor times out
    assign diff      = {1'b0, item.timestamp} - {1'b0, mark_reg};
    assign backwards = diff[TIME_W];
    assign over_min  = !backwards &&
                       (diff[TIME_W-1:0] > {{(TIME_W-DWELL_W){1'b0}}, cfg.min_dwell});
    assign over_max  = !backwards &&
                       (diff[TIME_W-1:0] > {{(TIME_W-DWELL_W){1'b0}}, cfg.max_dwell});

    assign low_hit  = item.frequency < cfg.low_thr;
    assign high_hit = item.frequency > cfg.high_thr;
    assign flag     = item.check_flag;

    assign limit_ext     = {1'b0, cfg.att_limit};
    assign timeout_count = limit_ext + TIMEOUT_OFFSET;
    assign fail_count    = {2'b00, cfg.att_limit} + FAIL_OFFSET;

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        mark_next   = mark_reg;
        cmd         = CMD_NONE;
        st          = ST_RUN;

        if (item.action == ACT_START)
        begin
            active_next = 1'b1;
            count_next  = '0;
            phase_next  = PH_CMD_LOW;
            mark_next   = item.timestamp;
        end
        else if (!active_reg)
        begin
            st = ST_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_CMD_LOW:
                begin
                    cmd        = CMD_LOW;
                    phase_next = PH_WAIT_LOW;
                end
                PH_WAIT_LOW:
                begin
                    // A fresh mark means zero dwell, so no timeout then
                    if (low_hit)
                    begin
                        mark_next  = item.timestamp;
                        phase_next = PH_CONF_LOW;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 5'd1;
                        end
                    end
                    else if (over_max)
                    begin
                        st          = ST_LOW_TO;
                        count_next  = timeout_count;
                        active_next = 1'b0;
                    end
                end
                PH_CONF_LOW:
                begin
                    if (over_max)
                    begin
                        st          = ST_LOW_TO;
                        count_next  = timeout_count;
                        active_next = 1'b0;
                    end
                    else if (over_min && low_hit)
                    begin
                        mark_next = item.timestamp;
                        if ((count_reg < limit_ext) && flag)
                        begin
                            st          = ST_OPENED;
                            active_next = 1'b0;
                        end
                        else if ((count_reg <= limit_ext) || !flag)
                        begin
                            if ({1'b0, count_reg} == fail_count)
                            begin
                                st          = ST_FAILED;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                phase_next = PH_CMD_HIGH;
                            end
                        end
                        else
                        begin
                            st          = ST_OPENED;
                            active_next = 1'b0;
                        end
                    end
                end
                PH_CMD_HIGH:
                begin
                    cmd        = CMD_HIGH;
                    phase_next = PH_WAIT_HIGH;
                end
                PH_WAIT_HIGH:
                begin
                    if (high_hit)
                    begin
                        mark_next  = item.timestamp;
                        phase_next = PH_CONF_HIGH;
                    end
                    else if (over_max)
                    begin
                        st          = ST_HIGH_TO;
                        count_next  = timeout_count;
                        active_next = 1'b0;
                    end
                end
                PH_CONF_HIGH:
                begin
                    if (over_max)
                    begin
                        st          = ST_HIGH_TO;
                        count_next  = timeout_count;
                        active_next = 1'b0;
                    end
                    else if (over_min && high_hit)
                    begin
                        mark_next  = item.timestamp;
                        phase_next = PH_CMD_LOW;
                    end
                end
                default:
                begin
                    st = ST_RUN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_CMD_LOW;
            count_reg  <= '0;
            mark_reg   <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            mark_reg   <= mark_next;
        end
    end

    assign result.speed_command = cmd;
    assign result.status        = st;

endmodule
